// File: src/tfst_pkg.sv
package tfst_pkg;

  localparam int PIXELS_DEF = 64;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_SKIP_FRAMES = 3'd0;
  localparam logic [2:0] REG_RANGE_LOW   = 3'd1;
  localparam logic [2:0] REG_RANGE_HIGH  = 3'd2;
  localparam logic [2:0] REG_THRESH_MIN  = 3'd3;
  localparam logic [2:0] REG_THRESH_MAX  = 3'd4;
  localparam logic [2:0] REG_TARGET_AREA = 3'd5;

  localparam logic [7:0]  SKIP_FRAMES_RST = 8'd10;
  localparam logic [15:0] THRESH_MIN_RST  = 16'd256;
  localparam logic [15:0] THRESH_MAX_RST  = 16'd1024;
  localparam logic [6:0]  TARGET_AREA_RST = 7'd8;

  // A step of 0.1 in eight fraction bits.
  localparam logic [16:0] STEP_CODE = 17'd26;
  localparam logic signed [11:0] MAX_PIXEL_DIFF = 12'sd200;
  localparam logic [7:0] AREA_MARGIN = 8'd2;

  localparam logic OP_AVG_D = 1'b0;
  localparam logic OP_AVG_B = 1'b1;

  typedef struct packed {
    logic [7:0]         skip_frames;
    logic signed [19:0] range_low;
    logic signed [19:0] range_high;
    logic [15:0]        thresh_min;
    logic [15:0]        thresh_max;
    logic [6:0]         target_area;
  } cfg_t;

  typedef struct packed {
    logic acc;
    logic mean;
    logic mul;
    logic add;
    logic start;
    logic store;
    logic thresh;
    logic out_load;
    logic op;
  } cmd_t;

  typedef struct packed {
    logic upd;
    logic div_done;
  } stat_t;

endpackage

// File: src/tfst_regs.sv
module tfst_regs
  import tfst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_frames <= SKIP_FRAMES_RST;
      cfg.range_low   <= '0;
      cfg.range_high  <= '0;
      cfg.thresh_min  <= THRESH_MIN_RST;
      cfg.thresh_max  <= THRESH_MAX_RST;
      cfg.target_area <= TARGET_AREA_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SKIP_FRAMES: cfg.skip_frames <= pwdata[7:0];
        REG_RANGE_LOW:   cfg.range_low   <= pwdata[19:0];
        REG_RANGE_HIGH:  cfg.range_high  <= pwdata[19:0];
        REG_THRESH_MIN:  cfg.thresh_min  <= pwdata[15:0];
        REG_THRESH_MAX:  cfg.thresh_max  <= pwdata[15:0];
        REG_TARGET_AREA: cfg.target_area <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SKIP_FRAMES: prdata = DATA_W'(cfg.skip_frames);
      REG_RANGE_LOW:   prdata = DATA_W'(unsigned'(cfg.range_low));
      REG_RANGE_HIGH:  prdata = DATA_W'(unsigned'(cfg.range_high));
      REG_THRESH_MIN:  prdata = DATA_W'(cfg.thresh_min);
      REG_THRESH_MAX:  prdata = DATA_W'(cfg.thresh_max);
      REG_TARGET_AREA: prdata = DATA_W'(cfg.target_area);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: src/tfst_div.sv
module tfst_div
  import tfst_pkg::*;
#(
  parameter int DW = 28,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, quot[DW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      rem  <= fits ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
      quot <= {quot[DW-2:0], fits};
    end
  end

endmodule

// File: src/tfst_dp.sv
module tfst_dp
  import tfst_pkg::*;
#(
  parameter int PIXELS = PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic signed [11:0] diff_temp,
  input  logic signed [11:0] back_temp,
  input  logic               last_pixel,
  input  logic [7:0]         frame_number,
  input  logic [6:0]         human_area,
  output logic signed [19:0] mean_diff,
  output logic [7:0]         max_diff,
  output logic signed [11:0] min_diff,
  output logic signed [19:0] mean_back,
  output logic [15:0]        threshold
);

  localparam int MEAN_W = 27 - $clog2(PIXELS + 1);
  localparam int RUN_W  = (MEAN_W > 20) ? MEAN_W : 20;
  localparam int DW     = RUN_W + 8;
  localparam int VW     = 8;
  localparam int TW     = RUN_W + 9;

  // The frame mean is floor(sum * 256 / PIXELS). The scaled sum is offset by a multiple of
  // PIXELS to make it non-negative, divided by an exact reciprocal multiply, and the
  // offset quotient is taken off again.
  localparam int XW    = 27;
  localparam int RW    = XW + 1;
  localparam int SH    = XW + $clog2(PIXELS);
  localparam int OFS_K = ((1 << 25) + PIXELS - 1) / PIXELS;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(PIXELS) - 1) / longint'(PIXELS);
  localparam logic [RW-1:0]    RECIP_C = RW'(RECIP);
  localparam logic [XW-1:0]    OFS_C   = XW'(OFS_K * PIXELS);
  localparam logic [RUN_W-1:0] OFS_Q   = RUN_W'(OFS_K);

  logic signed [17:0]      diff_sum, back_sum;
  logic [7:0]              frame_max;
  logic signed [11:0]      frame_min;
  logic                    first_pixel;
  logic [7:0]              cand;
  logic [7:0]              n_reg;
  logic [6:0]              area_reg;

  logic signed [RUN_W-1:0] mean_d, mean_b;
  logic signed [RUN_W-1:0] run_mean_diff, run_mean_back;
  logic [7:0]              run_max;
  logic signed [11:0]      run_min;
  logic [15:0]             cur_threshold;
  logic                    thresh_ready;

  logic signed [TW-1:0]    prod, t_reg;
  logic signed [RUN_W-1:0] old_sel, mean_sel;
  logic [7:0]              nm1;

  logic signed [25:0]      scaled_d, scaled_b;
  logic [XW-1:0]           biased_d, biased_b;
  logic [XW+RW-1:0]        mprod_d, mprod_b;

  logic [TW-1:0]           t_mag;
  logic [DW-1:0]           dividend;
  logic                    div_neg;
  logic [DW-1:0]           quot;
  logic [RUN_W:0]          q_trunc;
  logic signed [RUN_W-1:0] trunc_res;

  logic signed [RUN_W-1:0] lo_ext, hi_ext;
  logic [16:0]             mid, up;
  logic [15:0]             mid_sat, up_res, dn_res, init_thr;
  logic                    area_hi, area_lo;

  assign stat.upd = last_pixel && (frame_number > cfg.skip_frames);
  assign cand = (diff_temp > 12'sd0 && diff_temp <= MAX_PIXEL_DIFF) ? diff_temp[7:0] : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_sum    <= '0;
      back_sum    <= '0;
      frame_max   <= '0;
      frame_min   <= '0;
      first_pixel <= 1'b1;
    end else if (cmd.acc) begin
      first_pixel <= last_pixel;
      if (first_pixel) begin
        diff_sum  <= 18'(diff_temp);
        back_sum  <= 18'(back_temp);
        frame_max <= cand;
        frame_min <= diff_temp;
      end else begin
        diff_sum <= diff_sum + 18'(diff_temp);
        back_sum <= back_sum + 18'(back_temp);
        if (cand > frame_max) begin
          frame_max <= cand;
        end
        if (diff_temp < frame_min) begin
          frame_min <= diff_temp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && last_pixel) begin
      n_reg    <= frame_number - cfg.skip_frames;
      area_reg <= human_area;
    end
  end

  assign scaled_d = {diff_sum, 8'd0};
  assign scaled_b = {back_sum, 8'd0};
  assign biased_d = XW'(scaled_d) + OFS_C;
  assign biased_b = XW'(scaled_b) + OFS_C;

  always_ff @(posedge clk) begin
    if (cmd.mean) begin
      mprod_d <= biased_d * RECIP_C;
      mprod_b <= biased_b * RECIP_C;
    end
  end

  assign nm1      = n_reg - 8'd1;
  assign old_sel  = (cmd.op == OP_AVG_D) ? run_mean_diff : run_mean_back;
  assign mean_sel = (cmd.op == OP_AVG_D) ? mean_d : mean_b;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod   <= $signed({1'b0, nm1}) * old_sel;
      mean_d <= RUN_W'(mprod_d >> SH) - OFS_Q;
      mean_b <= RUN_W'(mprod_b >> SH) - OFS_Q;
    end
    if (cmd.add) begin
      t_reg <= prod + TW'(mean_sel);
    end
  end

  assign t_mag    = t_reg[TW-1] ? TW'(-t_reg) : TW'(t_reg);
  assign dividend = t_mag[DW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_neg <= t_reg[TW-1];
    end
  end

  tfst_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start),
    .dividend(dividend),
    .divisor (n_reg),
    .done    (stat.div_done),
    .quot    (quot)
  );

  assign q_trunc   = (RUN_W+1)'(quot);
  assign trunc_res = div_neg ? RUN_W'(-q_trunc) : RUN_W'(q_trunc);

  assign lo_ext  = RUN_W'($signed(cfg.range_low));
  assign hi_ext  = RUN_W'($signed(cfg.range_high));
  assign mid     = {1'b0, cfg.thresh_min} + STEP_CODE;
  assign mid_sat = mid[16] ? 16'hFFFF : mid[15:0];
  assign up      = {1'b0, cur_threshold} + STEP_CODE;
  assign up_res  = (up > {1'b0, cfg.thresh_max}) ? cfg.thresh_max : up[15:0];
  assign dn_res  = ({1'b0, cur_threshold} < ({1'b0, cfg.thresh_min} + STEP_CODE)) ?
                   cfg.thresh_min : 16'(cur_threshold - 16'(STEP_CODE));
  assign area_hi = {1'b0, area_reg} > ({1'b0, cfg.target_area} + AREA_MARGIN);
  assign area_lo = ({1'b0, area_reg} + AREA_MARGIN) < {1'b0, cfg.target_area};

  always_comb begin
    if (run_mean_back <= lo_ext) begin
      init_thr = cfg.thresh_min;
    end else if (run_mean_back <= hi_ext) begin
      init_thr = mid_sat;
    end else begin
      init_thr = cfg.thresh_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mean_diff <= '0;
      run_mean_back <= '0;
      run_max       <= '0;
      run_min       <= '0;
      cur_threshold <= '0;
      thresh_ready  <= 1'b0;
    end else begin
      if (cmd.store) begin
        case (cmd.op)
          OP_AVG_D: run_mean_diff <= trunc_res;
          OP_AVG_B: run_mean_back <= trunc_res;
          default: ;
        endcase
      end
      if (cmd.thresh) begin
        if (frame_max > run_max) begin
          run_max <= frame_max;
        end
        if (frame_min < run_min) begin
          run_min <= frame_min;
        end
        thresh_ready <= 1'b1;
        if (!thresh_ready) begin
          cur_threshold <= init_thr;
        end else if (area_hi) begin
          cur_threshold <= up_res;
        end else if (area_lo) begin
          cur_threshold <= dn_res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_diff <= run_mean_diff[19:0];
      mean_back <= run_mean_back[19:0];
      max_diff  <= run_max;
      min_diff  <= run_min;
      threshold <= cur_threshold;
    end
  end

endmodule

// File: src/tfst_ctrl.sv
module tfst_ctrl
  import tfst_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MEAN   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_ADD    = 3'd3;
  localparam logic [2:0] ST_START  = 3'd4;
  localparam logic [2:0] ST_WAIT   = 3'd5;
  localparam logic [2:0] ST_THRESH = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0] state, state_next;
  logic       op, op_next;
  logic       out_valid_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.acc = in_valid;
        if (in_valid && stat.upd) begin
          op_next    = OP_AVG_D;
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: begin
        cmd.mean   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat.div_done) begin
          cmd.store = 1'b1;
          unique case (op)
            OP_AVG_D: begin
              op_next    = OP_AVG_B;
              state_next = ST_MUL;
            end
            OP_AVG_B: begin
              state_next = ST_THRESH;
            end
          endcase
        end
      end
      ST_THRESH: begin
        cmd.thresh = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    cmd.op = op;
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_AVG_D;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: src/thermal_frame_stats_threshold_tuner_top.sv
// Channel   Direction  Handshake            Payload
// config    in         psel/penable/pready  paddr, pwdata, prdata
// pixel     in         in_valid/in_stall    diff_temp, back_temp, last_pixel,
//                                           frame_number, human_area
// result    out        out_valid/out_stall  mean_diff, max_diff, min_diff,
//                                           mean_back, threshold
//
// A pixel beat that does not close an updating frame is taken without stalling the input.
// A last pixel numbered above skip_frames stalls the input through two passes of a bit-serial
// divider by the frame count; the frame means come from a registered reciprocal multiply.
// Synchronous reset restores the configuration, control state, accumulators and running
// statistics at once; there is no clearing pass.
// The result beat sits in an output register, so pixels are taken while it is stalled;
// the next result waits until that register is free, and the input stalls meanwhile.
module thermal_frame_stats_threshold_tuner_top
  import tfst_pkg::*;
#(
  parameter int PIXELS = PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [11:0] diff_temp,
  input  logic signed [11:0] back_temp,
  input  logic               last_pixel,
  input  logic [7:0]         frame_number,
  input  logic [6:0]         human_area,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] mean_diff,
  output logic [7:0]         max_diff,
  output logic signed [11:0] min_diff,
  output logic signed [19:0] mean_back,
  output logic [15:0]        threshold
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  tfst_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  tfst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tfst_dp #(
    .PIXELS(PIXELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .stat        (stat),
    .diff_temp   (diff_temp),
    .back_temp   (back_temp),
    .last_pixel  (last_pixel),
    .frame_number(frame_number),
    .human_area  (human_area),
    .mean_diff   (mean_diff),
    .max_diff    (max_diff),
    .min_diff    (min_diff),
    .mean_back   (mean_back),
    .threshold   (threshold)
  );

endmodule

// File: src/tfst_check.sv
module tfst_check
  import tfst_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               last_pixel,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [19:0] mean_diff,
  input logic [7:0]         max_diff,
  input logic [15:0]        threshold
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid after reset");

  a_stalled_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(threshold) && $stable(mean_diff))
    else $error("stalled result beat changed");

  a_plain_pixel: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !last_pixel |=> !in_stall)
    else $error("input stalled after a pixel that does not end a frame");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat appeared without frame end processing");

  a_max_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> max_diff <= 8'd200)
    else $error("running maximum above the pixel limit");

endmodule

bind thermal_frame_stats_threshold_tuner_top tfst_check u_check (.*);

// File: dv/tb.sv
module tb;
  import tfst_pkg::*;

  localparam int LATENCY_CYCLES = 160;

  typedef struct packed {
    logic signed [19:0] mean_diff;
    logic [7:0]         max_diff;
    logic signed [11:0] min_diff;
    logic signed [19:0] mean_back;
    logic [15:0]        threshold;
  } stats_beat_t;

  class stats_scoreboard;
    logic [7:0]         skip_cfg;
    logic signed [19:0] band_lo;
    logic signed [19:0] band_hi;
    logic [15:0]        thr_floor;
    logic [15:0]        thr_ceil;
    logic [6:0]         area_goal;

    logic signed [17:0] diff_acc;
    logic signed [17:0] back_acc;
    logic [7:0]         frame_peak;
    logic signed [11:0] frame_low;
    bit                 at_frame_start;
    logic signed [19:0] avg_diff;
    logic signed [19:0] avg_back;
    logic [7:0]         peak_hold;
    logic signed [11:0] low_hold;
    logic [15:0]        thr;
    bit                 thr_set;

    stats_beat_t due[$];
    int errors;
    int pixels;
    int results;

    function new();
      skip_cfg = SKIP_FRAMES_RST;
      band_lo = '0;
      band_hi = '0;
      thr_floor = THRESH_MIN_RST;
      thr_ceil = THRESH_MAX_RST;
      area_goal = TARGET_AREA_RST;
      diff_acc = '0;
      back_acc = '0;
      frame_peak = '0;
      frame_low = '0;
      at_frame_start = 1'b1;
      avg_diff = '0;
      avg_back = '0;
      peak_hold = '0;
      low_hold = '0;
      thr = '0;
      thr_set = 1'b0;
      errors = 0;
      pixels = 0;
      results = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_SKIP_FRAMES: skip_cfg = val[7:0];
        REG_RANGE_LOW:   band_lo = val[19:0];
        REG_RANGE_HIGH:  band_hi = val[19:0];
        REG_THRESH_MIN:  thr_floor = val[15:0];
        REG_THRESH_MAX:  thr_ceil = val[15:0];
        REG_TARGET_AREA: area_goal = val[6:0];
        default: ;
      endcase
    endfunction

    function longint frame_mean(logic signed [17:0] acc);
      longint num;
      longint q;
      num = longint'(acc) * 256;
      q = num / PIXELS_DEF;
      if (num < 0 && num % PIXELS_DEF != 0) q = q - 1;
      return q;
    endfunction

    function void note_pixel(logic signed [11:0] d, logic signed [11:0] b, logic last,
                             logic [7:0] fnum, logic [6:0] area);
      logic [7:0] cand;
      longint n;
      longint t;
      stats_beat_t beat;
      pixels++;
      cand = (d > 12'sd0 && d <= MAX_PIXEL_DIFF) ? d[7:0] : 8'd0;
      if (at_frame_start) begin
        diff_acc = d;
        back_acc = b;
        frame_peak = cand;
        frame_low = d;
      end else begin
        diff_acc = diff_acc + d;
        back_acc = back_acc + b;
        if (cand > frame_peak) frame_peak = cand;
        if (d < frame_low) frame_low = d;
      end
      at_frame_start = last;
      if (!last || fnum <= skip_cfg) return;

      n = longint'(fnum) - longint'(skip_cfg);
      t = (n - 1) * longint'(avg_diff) + frame_mean(diff_acc);
      avg_diff = 20'(t / n);
      t = (n - 1) * longint'(avg_back) + frame_mean(back_acc);
      avg_back = 20'(t / n);
      if (frame_peak > peak_hold) peak_hold = frame_peak;
      if (frame_low < low_hold) low_hold = frame_low;

      if (!thr_set) begin
        if (avg_back <= band_lo) t = longint'(thr_floor);
        else if (avg_back <= band_hi) t = longint'(thr_floor) + longint'(STEP_CODE);
        else t = longint'(thr_ceil);
        if (t > 65535) t = 65535;
        thr_set = 1'b1;
      end else begin
        t = longint'(thr);
        if (longint'(area) > longint'(area_goal) + longint'(AREA_MARGIN)) begin
          t = t + longint'(STEP_CODE);
          if (t > longint'(thr_ceil)) t = longint'(thr_ceil);
        end else if (longint'(area) < longint'(area_goal) - longint'(AREA_MARGIN)) begin
          t = t - longint'(STEP_CODE);
          if (t < longint'(thr_floor)) t = longint'(thr_floor);
        end
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
      end
      thr = t[15:0];

      beat.mean_diff = avg_diff;
      beat.max_diff = peak_hold;
      beat.min_diff = low_hold;
      beat.mean_back = avg_back;
      beat.threshold = thr;
      due.push_back(beat);
    endfunction

    task match_field(string name, longint got, longint want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(logic signed [19:0] md, logic [7:0] mx, logic signed [11:0] mn,
                      logic signed [19:0] mb, logic [15:0] th);
      stats_beat_t want;
      results++;
      if (due.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = due.pop_front();
      match_field("mean_diff", md, want.mean_diff);
      match_field("max_diff", mx, want.max_diff);
      match_field("min_diff", mn, want.min_diff);
      match_field("mean_back", mb, want.mean_back);
      match_field("threshold", th, want.threshold);
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [11:0] diff_temp = '0;
  logic signed [11:0] back_temp = '0;
  logic               last_pixel = 1'b0;
  logic [7:0]         frame_number = '0;
  logic [6:0]         human_area = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [19:0] mean_diff;
  logic [7:0]         max_diff;
  logic signed [11:0] min_diff;
  logic signed [19:0] mean_back;
  logic [15:0]        threshold;

  stats_scoreboard sb;
  int  stall_left = 0;
  int  calm_left = 0;
  int  stall_pick;
  bit  steady_send = 1'b0;
  logic [7:0] frame_ctr = '0;
  int  settings = 0;

  thermal_frame_stats_threshold_tuner_top u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      out_stall <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall <= 1'b0;
      end else if (stall_pick < 80) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else if (stall_pick < 85) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(10, 200);
      end else begin
        out_stall <= 1'b0;
        calm_left <= $urandom_range(30, 400);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(mean_diff, max_diff, min_diff, mean_back, threshold);
  end

  task automatic write_cfg(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] mask;
    case (idx)
      REG_SKIP_FRAMES:                mask = 32'hff;
      REG_RANGE_LOW, REG_RANGE_HIGH:  mask = 32'hfffff;
      REG_THRESH_MIN, REG_THRESH_MAX: mask = 32'hffff;
      default:                        mask = 32'h7f;
    endcase
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    if ((prdata & mask) !== (val & mask))
      sb.report($sformatf("register %0d read back %0h expected %0h", idx, prdata & mask,
                          val & mask));
    sb.set_reg(idx, val);
  endtask

  task automatic send_pixel(input logic signed [11:0] d, input logic signed [11:0] b,
                            input logic last, input logic [7:0] fnum, input logic [6:0] area);
    int r;
    int gap;
    gap = 0;
    if (!steady_send) begin
      r = $urandom_range(0, 99);
      if (r >= 98) gap = $urandom_range(20, 80);
      else if (r >= 92) gap = $urandom_range(4, 12);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    diff_temp <= d;
    back_temp <= b;
    last_pixel <= last;
    frame_number <= fnum;
    human_area <= area;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_pixel(d, b, last, fnum, area);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic quiesce();
    wait_drained();
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_between(int lo, int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return lo;
    if (r < 4) return hi;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic signed [11:0] rand_temp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 12'($urandom);
    if (r < 80) return 12'($urandom_range(0, 300) - 50);
    case ($urandom_range(0, 5))
      0:       return 12'sd0;
      1:       return 12'sd200;
      2:       return 12'sd201;
      3:       return 12'shfff;
      4:       return 12'sh800;
      default: return 12'sh7ff;
    endcase
  endfunction

  function automatic logic [6:0] rand_area();
    int t;
    if ($urandom_range(0, 9) == 0) return 7'($urandom);
    t = int'(sb.area_goal) + int'($urandom_range(0, 12)) - 6;
    if (t < 0) t = 0;
    if (t > 64) t = 64;
    return 7'(t);
  endfunction

  task automatic shuffle_config();
    int skip_pick;
    skip_pick = $urandom_range(0, 9);
    if (skip_pick == 0) write_cfg(REG_SKIP_FRAMES, 32'd255);
    else if (skip_pick < 3) write_cfg(REG_SKIP_FRAMES, 32'd0);
    else write_cfg(REG_SKIP_FRAMES, $urandom_range(1, 30));
    write_cfg(REG_RANGE_LOW, pick_between(-524288, 524287));
    write_cfg(REG_RANGE_HIGH, pick_between(-524288, 524287));
    write_cfg(REG_THRESH_MIN, pick_between(0, 65535));
    write_cfg(REG_THRESH_MAX, pick_between(0, 65535));
    write_cfg(REG_TARGET_AREA, pick_between(0, 64));
    frame_ctr = sb.skip_cfg;
    settings++;
  endtask

  task automatic run_phase(input int budget);
    int sent;
    int len;
    int kind;
    int i;
    bit hot_sign;
    logic [7:0] fnum;
    logic [6:0] area;
    logic signed [11:0] d;
    logic signed [11:0] b;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 3) wait_drained();
      if (kind >= 97) len = $urandom_range(65, 90);
      else if (kind >= 90) len = $urandom_range(13, 40);
      else len = $urandom_range(1, 12);
      hot_sign = 1'($urandom_range(0, 1));
      steady_send = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 15) frame_ctr = 8'($urandom);
      else frame_ctr = frame_ctr + 8'd1;
      for (i = 0; i < len; i++) begin
        if (kind >= 97) begin
          d = hot_sign ? 12'sh7ff : 12'sh800;
          b = hot_sign ? 12'sh800 : 12'sh7ff;
        end else begin
          d = rand_temp();
          b = rand_temp();
        end
        if (i == len - 1) begin
          fnum = frame_ctr;
          area = rand_area();
        end else begin
          fnum = 8'($urandom);
          area = 7'($urandom);
        end
        send_pixel(d, b, i == len - 1, fnum, area);
        sent++;
      end
    end
    steady_send = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_cfg(REG_SKIP_FRAMES, 32'd0);
    write_cfg(REG_RANGE_LOW, -524288);
    write_cfg(REG_RANGE_HIGH, 524287);
    write_cfg(REG_THRESH_MIN, 32'd65530);
    write_cfg(REG_THRESH_MAX, 32'd65535);
    write_cfg(REG_TARGET_AREA, 32'd0);
    settings++;
    send_pixel(12'sd201, 12'sh7ff, 1'b0, 8'hff, 7'h7f);
    send_pixel(12'sd200, 12'sh800, 1'b0, 8'h00, 7'h00);
    send_pixel(12'sh800, 12'sd0, 1'b0, 8'h00, 7'h00);
    send_pixel(12'sh7ff, 12'sd1, 1'b1, 8'd1, 7'd64);
    send_pixel(12'sd5, 12'sd5, 1'b0, 8'd0, 7'd0);
    send_pixel(12'sd7, -12'sd7, 1'b1, 8'd0, 7'd64);
    send_pixel(12'shfff, 12'shfff, 1'b1, 8'd255, 7'd0);
    send_pixel(12'sd0, 12'sd0, 1'b1, 8'd2, 7'd3);
    quiesce();

    write_cfg(REG_SKIP_FRAMES, 32'd10);
    write_cfg(REG_THRESH_MIN, 32'd1000);
    write_cfg(REG_THRESH_MAX, 32'd500);
    write_cfg(REG_TARGET_AREA, 32'd64);
    settings++;
    send_pixel(12'sd100, -12'sd100, 1'b1, 8'd200, 7'd0);
    send_pixel(-12'sd100, 12'sd100, 1'b1, 8'd201, 7'd127);
    send_pixel(12'sd50, 12'sd60, 1'b1, 8'd10, 7'd64);
    quiesce();

    write_cfg(REG_SKIP_FRAMES, 32'd255);
    write_cfg(REG_THRESH_MIN, 32'd0);
    settings++;
    send_pixel(12'sd1, 12'sd1, 1'b1, 8'd255, 7'd10);
    quiesce();

    repeat (6) begin
      shuffle_config();
      run_phase(230);
      quiesce();
    end

    if (sb.pending() != 0) sb.report("expected results left over");
    $display("Run covered %0d pixel beats and %0d result beats across %0d register settings.",
             sb.pixels, sb.results, settings);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: thermal_frame_stats_threshold_tuner_top.f
src/tfst_pkg.sv
src/tfst_regs.sv
src/tfst_div.sv
src/tfst_dp.sv
src/tfst_ctrl.sv
src/thermal_frame_stats_threshold_tuner_top.sv
src/tfst_check.sv
dv/tb.sv
